[rtl/lesf_pkg.sv]
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared types and constants for the line element shape function core.
// ----------------------------------------------------------------------------
package lesf_pkg;

  // coordinate and intermediate widths
  localparam int PT_W    = 32;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 66;
  localparam int MAG_W   = 66;
  localparam int DEN_W   = 67;
  localparam int CAP_BITS = 27;
  localparam int T_W     = CAP_BITS + 1;
  localparam int OUT_W   = 19;
  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  // register indexes
  localparam logic [1:0] REG_NODE0_X = 2'd0;
  localparam logic [1:0] REG_NODE0_Y = 2'd1;
  localparam logic [1:0] REG_NODE1_X = 2'd2;
  localparam logic [1:0] REG_NODE1_Y = 2'd3;

  // control that travels with an item down the divider row
  typedef struct packed {
    logic valid;
    logic cap;
    logic deg;
  } lesf_ctl_t;

endpackage

[rtl/lesf_div_cell.sv]
// ----------------------------------------------------------------------------
// lesf_div_cell
// One restoring divider cell: decides one quotient bit and passes on.
// ----------------------------------------------------------------------------
module lesf_div_cell #(
  parameter int RW    = 94,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  lesf_pkg::lesf_ctl_t           ctl_in,
  input  logic [RW-1:0]                 rem_in,
  input  logic [lesf_pkg::DEN_W-1:0]    den_in,
  input  logic [lesf_pkg::CAP_BITS-1:0] q_in,
  output lesf_pkg::lesf_ctl_t           ctl,
  output logic [RW-1:0]                 rem,
  output logic [lesf_pkg::DEN_W-1:0]    den,
  output logic [lesf_pkg::CAP_BITS-1:0] q
);

  logic [RW-1:0] dsh;
  logic          ge;

  // shifted divisor and trial compare
  assign dsh = RW'(den_in) << SHIFT;
  assign ge  = rem_in >= dsh;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      den <= den_in;
      rem <= ge ? rem_in - dsh : rem_in;
      q   <= q_in | (ge ? (lesf_pkg::CAP_BITS)'(1) << SHIFT : '0);
    end
  end

endmodule

[rtl/line_element_shape_functions_core.sv]
// ----------------------------------------------------------------------------
// line_element_shape_functions_core
// Linear shape functions of a two-node line element at a projected point.
// ----------------------------------------------------------------------------
// channel   dir  signals                         payload
// s         in   s_tvalid s_tready s_tdata[63:0]  point_x, point_y
// m         out  m_tvalid m_tready m_tdata[39:0]  shape_first, shape_second
//                m_tuser[0]                       degenerate
// apb       in   psel penable pwrite paddr pwdata node0_x/y, node1_x/y
//
// one item per cycle while the output is not stalled; in the row of 27
// divider cells, each cell resolves one quotient bit.
// the whole pipeline advances when the output register is empty or taken,
// so s_tready follows m_tready combinationally.
// synchronous reset clears valid bits and restores node registers.
// ----------------------------------------------------------------------------
module line_element_shape_functions_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_x[31:0], point_y[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // shape_first[18:0], shape_second[37:19], zero
  output logic [0:0]  m_tuser,   // degenerate[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NUM_W = lesf_pkg::MAG_W + FRAC_BITS + 2;
  localparam int CD_W  = lesf_pkg::DEN_W + lesf_pkg::CAP_BITS;
  localparam int RW    = (NUM_W > CD_W) ? NUM_W : CD_W;
  localparam int NC    = lesf_pkg::CAP_BITS;

  logic [31:0] node0_x, node0_y, node1_x, node1_y;
  logic        adv;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node0_x <= '0;
      node0_y <= '0;
      node1_x <= 32'(64'(1) << FRAC_BITS);
      node1_y <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        lesf_pkg::REG_NODE0_X: node0_x <= pwdata;
        lesf_pkg::REG_NODE0_Y: node0_y <= pwdata;
        lesf_pkg::REG_NODE1_X: node1_x <= pwdata;
        lesf_pkg::REG_NODE1_Y: node1_y <= pwdata;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      lesf_pkg::REG_NODE0_X: prdata = node0_x;
      lesf_pkg::REG_NODE0_Y: prdata = node0_y;
      lesf_pkg::REG_NODE1_X: prdata = node1_x;
      lesf_pkg::REG_NODE1_Y: prdata = node1_y;
    endcase
  end

  // pipeline moves as a whole when the output can take an item
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: offsets from the first node
  logic                            v1;
  logic signed [lesf_pkg::DIFF_W-1:0] sx1, sy1, dx1, dy1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sx1 <= $signed({s_tdata[31], s_tdata[31:0]})  - $signed({node0_x[31], node0_x});
      sy1 <= $signed({s_tdata[63], s_tdata[63:32]}) - $signed({node0_y[31], node0_y});
      dx1 <= $signed({node1_x[31], node1_x}) - $signed({node0_x[31], node0_x});
      dy1 <= $signed({node1_y[31], node1_y}) - $signed({node0_y[31], node0_y});
    end
  end

  // stage 2: products
  logic                               v2;
  logic signed [lesf_pkg::PROD_W-1:0] pxx, pyy, pxs, pys;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pxx <= dx1 * dx1;
      pyy <= dy1 * dy1;
      pxs <= sx1 * dx1;
      pys <= sy1 * dy1;
    end
  end

  // stage 3: squared length and dot product
  logic                              v3;
  logic [lesf_pkg::MAG_W-1:0]        len3;
  logic signed [lesf_pkg::PROD_W:0]  dot3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      len3 <= $unsigned(pxx) + $unsigned(pyy);
      dot3 <= {pxs[lesf_pkg::PROD_W-1], pxs} + {pys[lesf_pkg::PROD_W-1], pys};
    end
  end

  // stage 4: magnitude of the dot product
  logic                       v4;
  logic [lesf_pkg::MAG_W-1:0] len4, adot4;
  logic [lesf_pkg::PROD_W:0]  ndot;
  assign ndot = dot3[lesf_pkg::PROD_W] ? -dot3 : dot3;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      len4  <= len3;
      adot4 <= ndot[lesf_pkg::MAG_W-1:0];
    end
  end

  // stage 5: rounded numerator and doubled divisor
  logic                       v5, deg5;
  logic [RW-1:0]              num5;
  logic [lesf_pkg::DEN_W-1:0] den5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      num5 <= (RW'(adot4) << (FRAC_BITS + 1)) + RW'(len4);
      den5 <= {len4, 1'b0};
      deg5 <= len4 == '0;
    end
  end

  // stage 6: quotient cap check
  lesf_pkg::lesf_ctl_t        ctl6;
  logic [RW-1:0]              num6;
  logic [lesf_pkg::DEN_W-1:0] den6;
  always_ff @(posedge clk) begin
    if (rst) ctl6 <= '0;
    else if (adv) begin
      ctl6.valid <= v5;
      ctl6.cap   <= num5 >= (RW'(den5) << lesf_pkg::CAP_BITS);
      ctl6.deg   <= deg5;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      num6 <= num5;
      den6 <= den5;
    end
  end

  // divider row, most significant quotient bit first
  lesf_pkg::lesf_ctl_t        c_ctl [NC+1];
  logic [RW-1:0]              c_rem [NC+1];
  logic [lesf_pkg::DEN_W-1:0] c_den [NC+1];
  logic [NC-1:0]              c_q   [NC+1];
  assign c_ctl[0] = ctl6;
  assign c_rem[0] = num6;
  assign c_den[0] = den6;
  assign c_q[0]   = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    lesf_div_cell #(.RW(RW), .SHIFT(NC - 1 - k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .ctl_in (c_ctl[k]),
      .rem_in (c_rem[k]),
      .den_in (c_den[k]),
      .q_in   (c_q[k]),
      .ctl    (c_ctl[k+1]),
      .rem    (c_rem[k+1]),
      .den    (c_den[k+1]),
      .q      (c_q[k+1])
    );
  end

  // saturation and output register
  logic [lesf_pkg::T_W-1:0]  t;
  logic signed [lesf_pkg::T_W+1:0] fst;
  logic [lesf_pkg::OUT_W-1:0] sat_first, sat_second;
  assign t   = c_ctl[NC].cap ? lesf_pkg::T_W'(1) << lesf_pkg::CAP_BITS
                             : {1'b0, c_q[NC]};
  assign fst = $signed((lesf_pkg::T_W+2)'(1) << FRAC_BITS) - $signed({2'b00, t});
  assign sat_second = (t > lesf_pkg::T_W'(lesf_pkg::OUT_MAX))
                    ? lesf_pkg::OUT_W'(lesf_pkg::OUT_MAX) : t[lesf_pkg::OUT_W-1:0];
  always_comb begin
    priority if (fst > $signed((lesf_pkg::T_W+2)'(lesf_pkg::OUT_MAX)))
      sat_first = lesf_pkg::OUT_W'(lesf_pkg::OUT_MAX);
    else if (fst < $signed((lesf_pkg::T_W+2)'(lesf_pkg::OUT_MIN)))
      sat_first = lesf_pkg::OUT_W'(lesf_pkg::OUT_MIN);
    else
      sat_first = fst[lesf_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= c_ctl[NC].valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata    <= c_ctl[NC].deg ? '0 : {2'b00, sat_second, sat_first};
      m_tuser[0] <= c_ctl[NC].deg;
    end
  end

  // checks
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output state");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("degenerate item with nonzero shapes");

  a_second_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[37])
    else $error("shape_second negative");

  a_valid_travels: assert property (@(posedge clk) disable iff (rst)
    (adv && c_ctl[NC].valid) |=> m_tvalid)
    else $error("divider result lost before output");

endmodule
